FILE: rtl/core/efrs_pkg.sv
package efrs_pkg;

  localparam int TIME_W = 32;
  localparam int END_W  = 48;
  localparam int CNT_W  = 32;
  localparam int CFG_W  = 5;
  localparam int ROOM_W = 4;

  localparam logic [END_W-1:0] END_MAX   = '1;
  localparam logic [CFG_W-1:0] ROOMS_RST = 5'd16;

  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
    logic              last_meeting;
  } req_t;

  typedef struct packed {
    logic [ROOM_W-1:0] assigned_room;
    logic [END_W-1:0]  scheduled_end;
    logic [ROOM_W-1:0] most_booked_room;
    logic              final_result;
  } res_t;

  typedef struct packed {
    logic load_item;
    logic scan_clr;
    logic scan_run;
    logic scan_max;
    logic upd_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic last;
    logic out_free;
  } sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_MAX,
    ST_FIN
  } state_e;

endpackage

FILE: rtl/core/efrs_item_if.sv
interface efrs_item_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/efrs_ctrl.sv
module efrs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  efrs_pkg::sts_t sts_i,
  output efrs_pkg::cmd_t cmd_o
);
  import efrs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.scan_done) state_d = ST_UPD;
      end
      ST_UPD: begin
        state_d = sts_i.last ? ST_MAX : ST_FIN;
      end
      ST_MAX: begin
        if (sts_i.scan_done) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
        cmd_o.scan_clr  = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.scan_run = 1'b1;
      end
      ST_UPD: begin
        cmd_o.upd_wr   = 1'b1;
        cmd_o.scan_clr = 1'b1;
      end
      ST_MAX: begin
        cmd_o.scan_run = 1'b1;
        cmd_o.scan_max = 1'b1;
      end
      ST_FIN: begin
        cmd_o.out_load = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

FILE: rtl/core/efrs_dp.sv
module efrs_dp #(
  parameter int ROOMS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  efrs_pkg::req_t               req_i,
  input  logic                         cfg_we_i,
  input  logic [efrs_pkg::CFG_W-1:0]   cfg_data_i,
  input  efrs_pkg::cmd_t               cmd_i,
  output efrs_pkg::sts_t               sts_o,
  output efrs_pkg::res_t               res_o,
  output logic                         res_valid_o,
  input  logic                         res_ready_i
);
  import efrs_pkg::*;

  localparam int RW = (ROOMS > 1) ? $clog2(ROOMS) : 1;
  localparam int NW = $clog2(ROOMS + 1);

  logic [CFG_W-1:0]  rooms_q;
  logic [NW-1:0]     n_act, n_q;
  logic [TIME_W-1:0] start_q, dur_q;
  logic              last_q;

  logic [NW-1:0]     cnt_q;
  logic              rd_vld_q;
  logic [RW-1:0]     rd_idx_q;
  logic              rd_en;
  logic [RW-1:0]     rd_addr;

  logic [END_W-1:0]  end_mem [ROOMS];
  logic [CNT_W-1:0]  cnt_mem [ROOMS];
  logic [ROOMS-1:0]  vld_q;
  logic [END_W-1:0]  end_rd_q, e_eff;
  logic [CNT_W-1:0]  cnt_rd_q, c_eff;
  logic              ent_vld_rd_q;

  logic              found_q;
  logic [RW-1:0]     free_idx_q, min_idx_q, top_idx_q, pick_q, pick_sel;
  logic [CNT_W-1:0]  free_cnt_q, min_cnt_q, top_cnt_q, pick_cnt, cnt_inc;
  logic [END_W-1:0]  min_end_q, fin_q, begin_t, fin_d;
  logic [END_W:0]    sum;

  res_t              res_q;
  logic              out_valid_q;

  // Room count register; zero acts as one, values above ROOMS act as ROOMS.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rooms_q <= ROOMS_RST;
    end else if (cfg_we_i) begin
      rooms_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (rooms_q == '0) begin
      n_act = NW'(1);
    end else if (int'(rooms_q) > ROOMS) begin
      n_act = NW'(ROOMS);
    end else begin
      n_act = NW'(rooms_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      n_q     <= n_act;
      start_q <= req_i.start_time;
      dur_q   <= (req_i.end_time > req_i.start_time) ?
                 req_i.end_time - req_i.start_time : '0;
      last_q  <= req_i.last_meeting;
    end
  end

  // Scan counter: one room address issued per cycle, its data registered for the next cycle.
  assign rd_en   = cmd_i.scan_run && (cnt_q < n_q);
  assign rd_addr = cnt_q[RW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
    end else if (cmd_i.scan_clr) begin
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
    end else if (cmd_i.scan_run) begin
      rd_vld_q <= rd_en;
      if (rd_en) cnt_q <= cnt_q + NW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_idx_q <= rd_addr;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_wr) begin
      end_mem[pick_sel] <= fin_d;
      cnt_mem[pick_sel] <= cnt_inc;
    end
    if (rd_en) begin
      end_rd_q     <= end_mem[rd_addr];
      cnt_rd_q     <= cnt_mem[rd_addr];
      ent_vld_rd_q <= vld_q[rd_addr];
    end
  end

  // A room never written since the last clear reads as zero.
  assign e_eff = ent_vld_rd_q ? end_rd_q : '0;
  assign c_eff = ent_vld_rd_q ? cnt_rd_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i.out_load && last_q) begin
      vld_q <= '0;
    end else if (cmd_i.upd_wr) begin
      vld_q[pick_sel] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.scan_clr) begin
      found_q <= 1'b0;
    end else if (cmd_i.scan_run && rd_vld_q && !cmd_i.scan_max &&
                 (e_eff <= END_W'(start_q))) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_run && rd_vld_q) begin
      if (!cmd_i.scan_max) begin
        if (!found_q && (e_eff <= END_W'(start_q))) begin
          free_idx_q <= rd_idx_q;
          free_cnt_q <= c_eff;
        end
        if ((rd_idx_q == '0) || (e_eff < min_end_q)) begin
          min_idx_q <= rd_idx_q;
          min_end_q <= e_eff;
          min_cnt_q <= c_eff;
        end
      end else begin
        if ((rd_idx_q == '0) || (c_eff > top_cnt_q)) begin
          top_idx_q <= rd_idx_q;
          top_cnt_q <= c_eff;
        end
      end
    end
  end

  // Update: the first free room, else the earliest-ending one with the delay kept.
  assign pick_sel = found_q ? free_idx_q : min_idx_q;
  assign pick_cnt = found_q ? free_cnt_q : min_cnt_q;
  assign begin_t  = found_q ? END_W'(start_q) : min_end_q;
  assign sum      = {1'b0, begin_t} + (END_W + 1)'(dur_q);
  assign fin_d    = sum[END_W] ? END_MAX : sum[END_W-1:0];
  assign cnt_inc  = (pick_cnt == '1) ? pick_cnt : pick_cnt + CNT_W'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_wr) begin
      pick_q <= pick_sel;
      fin_q  <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_q.assigned_room    <= ROOM_W'(pick_q);
      res_q.scheduled_end    <= fin_q;
      res_q.most_booked_room <= last_q ? ROOM_W'(top_idx_q) : '0;
      res_q.final_result     <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = out_valid_q;

  assign sts_o.scan_done = (cnt_q == n_q) && !rd_vld_q;
  assign sts_o.last      = last_q;
  assign sts_o.out_free  = !out_valid_q || res_ready_i;

endmodule

FILE: rtl/core/earliest_free_room_scheduler_core.sv
// Meeting room scheduler. Requests arrive on req_i (start_time, end_time,
// last_meeting) in non-decreasing start order; each yields one item on res_o
// with the assigned room and the scheduled end. The room count is written on
// cfg_i, which is always ready, and should only change while the block is idle.
// Each request scans the N active rooms one per cycle through the end-time
// and booking-count memories, then writes the chosen room back. A last
// request adds a second scan of the booking counts for the most-booked room,
// after which all room state reads as zero again. The next request is
// accepted as soon as a result is in the output register, even if the receiver
// has not taken it; a stalled receiver holds the result and stops the block
// only when the following result is ready. Reset empties all rooms, clears the
// output valid flag and sets the room count to 16.
module earliest_free_room_scheduler_core #(
  parameter int ROOMS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  efrs_item_if.sink         req_i,
  efrs_item_if.source       res_o,
  efrs_item_if.sink         cfg_i
);
  import efrs_pkg::*;

  cmd_t cmd;
  sts_t sts;
  res_t res;
  logic res_valid;
  logic req_ready;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = req_ready;
  assign res_o.valid = res_valid;
  assign res_o.data  = res;

  efrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  efrs_dp #(
    .ROOMS (ROOMS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i.data),
    .cfg_we_i    (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_ready_i (res_o.ready)
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import efrs_pkg::*;

  localparam int NUM_ROOMS = 16;

  typedef enum int {
    RX_STEADY,
    RX_SPOTTY,
    RX_LONG
  } rx_mode_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  efrs_item_if #(.T(req_t)) req_if ();
  efrs_item_if #(.T(res_t)) res_if ();
  efrs_item_if #(.T(logic [CFG_W-1:0])) cfg_if ();

  earliest_free_room_scheduler_core #(
    .ROOMS(NUM_ROOMS)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  // Shadow copy of the room state and the room count.
  logic [END_W-1:0] room_busy_until[NUM_ROOMS];
  logic [CNT_W-1:0] room_bookings[NUM_ROOMS];
  logic [CFG_W-1:0] room_limit;

  req_t meeting_requests[$];
  res_t expected_bookings[$];

  int       mismatches = 0;
  bit       req_taken = 1'b0;
  int       burst_left = 0;
  int       gap_left = 0;
  rx_mode_e rx_mode = RX_STEADY;
  int       mode_left = 0;
  int       hold_left = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic res_t schedule_meeting(req_t r);
    int n;
    int pick;
    int top;
    bit found;
    logic [END_W-1:0] dur;
    logic [END_W-1:0] begin_at;
    logic [END_W-1:0] finish;
    logic [CNT_W-1:0] best;
    res_t o;
    n = (room_limit == 0) ? 1 : ((room_limit > NUM_ROOMS) ? NUM_ROOMS : int'(room_limit));
    dur = (r.end_time > r.start_time) ? END_W'(r.end_time - r.start_time) : '0;
    found = 1'b0;
    pick = 0;
    for (int i = 0; i < n; i++) begin
      if (!found && room_busy_until[i] <= END_W'(r.start_time)) begin
        pick = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      for (int i = 1; i < n; i++) begin
        if (room_busy_until[i] < room_busy_until[pick]) pick = i;
      end
      begin_at = room_busy_until[pick];
    end else begin
      begin_at = END_W'(r.start_time);
    end
    finish = (dur > END_MAX - begin_at) ? END_MAX : begin_at + dur;
    room_busy_until[pick] = finish;
    if (room_bookings[pick] != '1) room_bookings[pick] = room_bookings[pick] + 1'b1;

    o.assigned_room = pick[ROOM_W-1:0];
    o.scheduled_end = finish;
    o.most_booked_room = '0;
    o.final_result = 1'b0;
    if (r.last_meeting) begin
      top = 0;
      best = room_bookings[0];
      for (int i = 1; i < n; i++) begin
        if (room_bookings[i] > best) begin
          best = room_bookings[i];
          top = i;
        end
      end
      o.most_booked_room = top[ROOM_W-1:0];
      o.final_result = 1'b1;
      for (int i = 0; i < NUM_ROOMS; i++) begin
        room_busy_until[i] = '0;
        room_bookings[i] = '0;
      end
    end
    return o;
  endfunction

  // Result check first, then prediction for a newly accepted request.
  always @(posedge clk) begin
    res_t want;
    bit bad;
    if (!rst_n) begin
      req_taken <= 1'b0;
      room_limit = ROOMS_RST;
      for (int i = 0; i < NUM_ROOMS; i++) begin
        room_busy_until[i] = '0;
        room_bookings[i] = '0;
      end
    end else begin
      req_taken <= req_if.valid && req_if.ready;
      if (res_if.valid && res_if.ready) begin
        if (expected_bookings.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: room %0d end %0h",
                                         res_if.data.assigned_room,
                                         res_if.data.scheduled_end);
        end else begin
          want = expected_bookings.pop_front();
          bad = (res_if.data.assigned_room !== want.assigned_room) ||
                (res_if.data.scheduled_end !== want.scheduled_end) ||
                (res_if.data.most_booked_room !== want.most_booked_room) ||
                (res_if.data.final_result !== want.final_result);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch at %0t (expected/actual): room %0d/%0d end %0h/%0h",
                       $realtime, want.assigned_room, res_if.data.assigned_room,
                       want.scheduled_end, res_if.data.scheduled_end);
              $display("  most booked %0d/%0d final %0b/%0b",
                       want.most_booked_room, res_if.data.most_booked_room,
                       want.final_result, res_if.data.final_result);
            end
          end
        end
      end
      if (req_if.valid && req_if.ready)
        expected_bookings.push_back(schedule_meeting(req_if.data));
      if (cfg_if.valid && cfg_if.ready) room_limit = cfg_if.data;
    end
  end

  // Request driver: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (req_if.valid && !req_taken) begin
      // Item still waiting for ready; hold it.
    end else if (gap_left > 0) begin
      req_if.valid <= 1'b0;
      gap_left--;
    end else if (meeting_requests.size() > 0) begin
      req_if.valid <= 1'b1;
      req_if.data <= meeting_requests.pop_front();
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        if ($urandom_range(0, 5) == 0) begin
          burst_left = $urandom_range(50, 200);
          gap_left = 0;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
      end
    end else begin
      req_if.valid <= 1'b0;
    end
  end

  // Result receiver: switches between steady, spotty and long-stall behavior.
  always @(negedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(40, 300);
        hold_left = 0;
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_STEADY: res_if.ready <= 1'b1;
        RX_SPOTTY: res_if.ready <= ($urandom_range(0, 9) < 7);
        default: begin
          if (hold_left == 0) begin
            res_if.ready <= !res_if.ready;
            hold_left = $urandom_range(1, 25);
          end else begin
            hold_left--;
          end
        end
      endcase
    end
  end

  task automatic add_meeting(logic [TIME_W-1:0] s, logic [TIME_W-1:0] e, logic l);
    req_t r;
    r.start_time = s;
    r.end_time = e;
    r.last_meeting = l;
    meeting_requests.push_back(r);
  endtask

  // Sets of meetings with mostly rising starts; a few out of order, inverted or pure noise.
  task automatic add_random_sets(int count);
    int made;
    int len;
    int span;
    int reach;
    int kind;
    bit open_tail;
    logic [TIME_W:0] t;
    logic [TIME_W:0] e;
    req_t r;
    made = 0;
    while (made < count) begin
      len = $urandom_range(1, 40);
      if (len > count - made) len = count - made;
      // The final set of a phase is sometimes left open across the count change.
      open_tail = (len == count - made) && ($urandom_range(0, 2) == 0);
      t = ($urandom_range(0, 3) == 0) ? {1'b0, $urandom()} : $urandom_range(0, 2000);
      span = $urandom_range(0, 60);
      reach = ($urandom_range(0, 4) == 0) ? 32'h7FFF_FFFF : $urandom_range(1, 300);
      for (int k = 0; k < len; k++) begin
        kind = $urandom_range(0, 99);
        if (kind < 4) begin
          r.start_time = $urandom();
          r.end_time = $urandom();
        end else begin
          t = t + $urandom_range(0, span);
          if (t[TIME_W]) t = {1'b0, {TIME_W{1'b1}}};
          r.start_time = t[TIME_W-1:0];
          if (kind < 8) r.start_time = t[TIME_W-1:0] - $urandom_range(1, 100);
          if (kind < 14) begin
            r.end_time = r.start_time - $urandom_range(0, 5);
          end else begin
            e = {1'b0, r.start_time} + (TIME_W+1)'($urandom_range(1, reach));
            if (e[TIME_W]) e = {1'b0, {TIME_W{1'b1}}};
            r.end_time = e[TIME_W-1:0];
          end
        end
        r.last_meeting = (k == len - 1) && !open_tail;
        meeting_requests.push_back(r);
      end
      made += len;
    end
  endtask

  task automatic drain_and_settle();
    @(posedge clk);
    while (meeting_requests.size() != 0 || req_if.valid || expected_bookings.size() != 0)
      @(posedge clk);
    repeat (2 * NUM_ROOMS + 7) @(posedge clk);
  endtask

  task automatic write_rooms(logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] settings[10] = '{5'd1, 5'd0, 5'd16, 5'd31, 5'd5,
                                       5'd17, 5'd2, 5'd9, 5'd12, 5'd3};
    req_if.valid = 1'b0;
    req_if.data = '0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset room count: zero-length meeting, full-range times, a room freed exactly
    // at the start, an out-of-order start with its end before its start.
    add_meeting(32'd0, 32'd0, 1'b0);
    add_meeting(32'd0, 32'hFFFF_FFFF, 1'b0);
    add_meeting(32'd5, 32'd10, 1'b0);
    add_meeting(32'd10, 32'd20, 1'b0);
    add_meeting(32'd3, 32'd1, 1'b0);
    add_meeting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    drain_and_settle();

    // Two rooms: no free room forces delays onto the earliest finishing room.
    write_rooms(5'd2);
    add_meeting(32'd0, 32'd100, 1'b0);
    add_meeting(32'd0, 32'd50, 1'b0);
    add_meeting(32'd10, 32'd30, 1'b0);
    add_meeting(32'd20, 32'd25, 1'b0);
    add_meeting(32'd60, 32'd60, 1'b0);
    add_meeting(32'd200, 32'd300, 1'b1);
    add_meeting(32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b0);
    add_meeting(32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b0);
    add_meeting(32'hFFFF_FFF1, 32'hFFFF_FFFF, 1'b1);
    drain_and_settle();

    foreach (settings[i]) begin
      write_rooms(settings[i]);
      add_random_sets(185);
      drain_and_settle();
    end

    if (mismatches == 0 && expected_bookings.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/efrs_pkg.sv
rtl/core/efrs_item_if.sv
rtl/core/efrs_ctrl.sv
rtl/core/efrs_dp.sv
rtl/core/earliest_free_room_scheduler_core.sv
tb/tb.sv
